// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_ON(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sdf_pkg.sv -----
// ----------------------------------------------------------------------------
// sdf_pkg
// widths, display codes and shared types of the signed decimal formatter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdf_pkg;

    localparam int VALUE_W    = 28;
    localparam int KIND_W     = 1;
    localparam int CODE_W     = 4;
    localparam int POINT_W    = 3;
    localparam int LOWER_W    = 11;
    localparam int UPPER_W    = 14;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int CMP_W      = VALUE_W + 1;
    localparam int NUM_W      = 14;
    localparam int NUM_POS    = 4;

    localparam int NEG_CAP     = -999;
    localparam int POS_CAP     = 9999;
    localparam int FRAC_DIGITS = 10000;

    localparam int DEFAULT_FRACTION_SCALE = 10000;

    typedef logic [CODE_W-1:0] code_t;

    localparam code_t CODE_MINUS = CODE_W'(10);
    localparam code_t CODE_BLANK = CODE_W'(11);
    localparam code_t CODE_OOR   = CODE_W'(12);

    localparam logic [KIND_W-1:0]  KIND_FIXED = 1'b1;
    localparam logic [POINT_W-1:0] POINT_NONE = POINT_W'(0);
    localparam logic [POINT_W-1:0] POINT_LAST = POINT_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER_LIMIT = 1'b0,
        REG_UPPER_LIMIT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic fixed;
        logic oor;
        logic neg;
    } tag_t;

endpackage

// ----- rtl/sdf_if.sv -----
// ----------------------------------------------------------------------------
// sdf interfaces
// valid/ready channels for input samples and formatted display words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sdf_sample_if import sdf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, kind, value, input ready);
    modport sink   (input valid, kind, value, output ready);
endinterface

interface sdf_display_if import sdf_pkg::*; ();
    logic               valid;
    logic               ready;
    code_t              position_one;
    code_t              position_two;
    code_t              position_three;
    code_t              position_four;
    logic [POINT_W-1:0] point_position;

    modport source (output valid, position_one, position_two, position_three,
                    position_four, point_position, input ready);
    modport sink   (input valid, position_one, position_two, position_three,
                    position_four, point_position, output ready);
endinterface

// ----- rtl/sdf_cdiv.sv -----
// ----------------------------------------------------------------------------
// sdf_cdiv
// two-stage divide by a constant: reciprocal multiply, then one correction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdf_cdiv import sdf_pkg::*; #(
    parameter int DIVISOR = DEFAULT_FRACTION_SCALE,
    parameter int IN_W    = VALUE_W,
    parameter int Q_W     = NUM_W
) (
    input  logic                         clk,
    input  logic [1:0]                   en,
    input  logic [IN_W-1:0]              x,
    output logic [Q_W-1:0]               q,
    output logic [$clog2(DIVISOR)-1:0]   r
);

    localparam int     R_W   = $clog2(DIVISOR);
    localparam longint RECIP = (longint'(1) << IN_W) / DIVISOR;
    localparam int     M_W   = $clog2(RECIP + 1);
    localparam int     P_W   = IN_W + M_W;

    localparam logic [M_W-1:0]  RECIP_C = M_W'(RECIP);
    localparam logic [IN_W-1:0] DIV_C   = IN_W'(DIVISOR);

    logic [P_W-1:0]  prod;
    logic [IN_W-1:0] x_reg;
    logic [Q_W-1:0]  q0_reg;
    logic [IN_W-1:0] diff;
    logic            corr;
    logic [Q_W-1:0]  q_reg;
    logic [R_W-1:0]  r_reg;

    // estimate is exact or one short
    assign prod = P_W'(x) * P_W'(RECIP_C);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg  <= x;
            q0_reg <= prod[IN_W +: Q_W];
        end
    end

    assign diff = x_reg - IN_W'(q0_reg) * DIV_C;
    assign corr = diff >= DIV_C;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            q_reg <= corr ? q0_reg + Q_W'(1) : q0_reg;
            r_reg <= corr ? R_W'(diff - DIV_C) : R_W'(diff);
        end
    end

    assign q = q_reg;
    assign r = r_reg;

endmodule

// ----- rtl/signed_decimal_digit_formatter.sv -----
// ----------------------------------------------------------------------------
// signed_decimal_digit_formatter
// throughput: one word per cycle unless the receiver stalls the output
// structure: nine register stages, two divider units
// reset: clears all stage valid bits; limits return to -999 and 9999
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module signed_decimal_digit_formatter import sdf_pkg::*; #(
    parameter int FRACTION_SCALE = DEFAULT_FRACTION_SCALE
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sdf_sample_if.sink            sample,
    sdf_display_if.source         display
);

    localparam int MAG_W    = $clog2(POS_CAP * FRACTION_SCALE + 1);
    localparam int FN_W     = $clog2((FRACTION_SCALE - 1) * FRAC_DIGITS + 1);
    localparam int R_W      = $clog2(FRACTION_SCALE);
    localparam int NSTAGE   = 9;
    localparam int RECIP_W  = 16;

    localparam logic signed [LOWER_W-1:0] LOWER_CAP = LOWER_W'(NEG_CAP);
    localparam logic [UPPER_W-1:0]        UPPER_CAP = UPPER_W'(POS_CAP);
    localparam logic signed [CMP_W-1:0]   SCALE_C   = CMP_W'(FRACTION_SCALE);
    localparam logic signed [CMP_W-1:0]   LOWER_FX_RST = CMP_W'(NEG_CAP * FRACTION_SCALE);
    localparam logic signed [CMP_W-1:0]   UPPER_FX_RST = CMP_W'(POS_CAP * FRACTION_SCALE);

    localparam logic [RECIP_W-1:0] RECIP_10   = RECIP_W'(52429);
    localparam logic [RECIP_W-1:0] RECIP_100  = RECIP_W'(5243);
    localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'(8389);
    localparam int SHIFT_10   = 19;
    localparam int SHIFT_100  = 19;
    localparam int SHIFT_1000 = 23;

    localparam logic [NUM_W-1:0] TEN = NUM_W'(10);

    function automatic logic [NUM_W-1:0] recip_quot(
        input logic [NUM_W-1:0]   x,
        input logic [RECIP_W-1:0] recip,
        input int                 shift
    );
        logic [NUM_W+RECIP_W-1:0] p;
        p = (NUM_W+RECIP_W)'(x) * (NUM_W+RECIP_W)'(recip);
        return NUM_W'(p >> shift);
    endfunction

    // limit registers
    logic signed [LOWER_W-1:0] lower_reg, lower_next;
    logic [UPPER_W-1:0]        upper_reg, upper_next;
    logic signed [CMP_W-1:0]   lower_fx_reg, lower_fx_next;
    logic signed [CMP_W-1:0]   upper_fx_reg, upper_fx_next;
    logic signed [LOWER_W-1:0] lower_raw, lower_clamp;
    logic [UPPER_W-1:0]        upper_raw, upper_clamp;

    always_comb
    begin
        lower_raw     = signed'(cfg_data[LOWER_W-1:0]);
        upper_raw     = cfg_data[UPPER_W-1:0];
        lower_clamp   = (lower_raw < LOWER_CAP) ? LOWER_CAP : lower_raw;
        upper_clamp   = (upper_raw > UPPER_CAP) ? UPPER_CAP : upper_raw;
        lower_next    = lower_reg;
        upper_next    = upper_reg;
        lower_fx_next = lower_fx_reg;
        upper_fx_next = upper_fx_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LOWER_LIMIT:
                begin
                    lower_next    = lower_clamp;
                    lower_fx_next = CMP_W'(lower_clamp) * SCALE_C;
                end
                REG_UPPER_LIMIT:
                begin
                    upper_next    = upper_clamp;
                    upper_fx_next = signed'(CMP_W'(upper_clamp)) * SCALE_C;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg    <= LOWER_CAP;
            upper_reg    <= UPPER_CAP;
            lower_fx_reg <= LOWER_FX_RST;
            upper_fx_reg <= UPPER_FX_RST;
        end
        else
        begin
            lower_reg    <= lower_next;
            upper_reg    <= upper_next;
            lower_fx_reg <= lower_fx_next;
            upper_fx_reg <= upper_fx_next;
        end
    end

    // stage handshake
    logic [NSTAGE-1:0] valid_reg, valid_next;
    logic [NSTAGE-1:0] en;

    always_comb
    begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || display.ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
            en[i] = !valid_reg[i] || en[i+1];
        valid_next[0] = en[0] ? sample.valid : valid_reg[0];
        for (int i = 1; i < NSTAGE; i++)
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign sample.ready  = en[0];
    assign display.valid = valid_reg[NSTAGE-1];

    // stage 0: range check and magnitude
    logic signed [CMP_W-1:0]   v_ext, lo_b, hi_b;
    logic signed [VALUE_W-1:0] abs_v;
    tag_t                      s0_tag_next;
    logic [MAG_W-1:0]          s0_mag_next;

    always_comb
    begin
        s0_tag_next.fixed = sample.kind == KIND_FIXED;
        s0_tag_next.neg   = sample.value[VALUE_W-1];
        v_ext = CMP_W'(sample.value);
        lo_b  = s0_tag_next.fixed ? lower_fx_reg : CMP_W'(lower_reg);
        hi_b  = s0_tag_next.fixed ? upper_fx_reg : signed'(CMP_W'(upper_reg));
        s0_tag_next.oor = (v_ext < lo_b) || (v_ext > hi_b);
        abs_v = s0_tag_next.neg ? -sample.value : sample.value;
        s0_mag_next = abs_v[MAG_W-1:0];
    end

    tag_t             tag_reg [NSTAGE-1];
    logic [MAG_W-1:0] mag_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            tag_reg[0] <= s0_tag_next;
            mag_reg[0] <= s0_mag_next;
        end
        for (int i = 1; i < NSTAGE - 1; i++)
        begin
            if (en[i])
                tag_reg[i] <= tag_reg[i-1];
        end
        for (int i = 1; i < 3; i++)
        begin
            if (en[i])
                mag_reg[i] <= mag_reg[i-1];
        end
    end

    // stages 1-2: whole part and remainder
    logic [NUM_W-1:0] div1_q;
    logic [R_W-1:0]   div1_r;

    sdf_cdiv #(
        .DIVISOR (FRACTION_SCALE),
        .IN_W    (MAG_W),
        .Q_W     (NUM_W)
    ) u_whole_div (
        .clk (clk),
        .en  (en[2:1]),
        .x   (mag_reg[0]),
        .q   (div1_q),
        .r   (div1_r)
    );

    // stage 3: scale remainder to four fraction digits
    logic [NUM_W-1:0] s3_whole_next;
    logic [R_W-1:0]   s3_rem;
    logic [FN_W-1:0]  s3_fn_next;
    logic [NUM_W-1:0] whole_reg [3];
    logic [FN_W-1:0]  fn_reg;

    always_comb
    begin
        s3_whole_next = tag_reg[2].fixed ? div1_q : mag_reg[2][NUM_W-1:0];
        s3_rem        = tag_reg[2].fixed ? div1_r : R_W'(0);
        s3_fn_next    = FN_W'(s3_rem) * FN_W'(FRAC_DIGITS);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            whole_reg[0] <= s3_whole_next;
            fn_reg       <= s3_fn_next;
        end
        for (int i = 1; i < 3; i++)
        begin
            if (en[i+3])
                whole_reg[i] <= whole_reg[i-1];
        end
    end

    // stages 4-5: fraction digits value
    logic [NUM_W-1:0] div2_q;
    logic [R_W-1:0]   div2_r;

    sdf_cdiv #(
        .DIVISOR (FRACTION_SCALE),
        .IN_W    (FN_W),
        .Q_W     (NUM_W)
    ) u_frac_div (
        .clk (clk),
        .en  (en[5:4]),
        .x   (fn_reg),
        .q   (div2_q),
        .r   (div2_r)
    );

    // stage 6: decimal quotients
    logic [NUM_W-1:0] wq_reg [4];
    logic [NUM_W-1:0] fq_reg [1:3];

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            wq_reg[0] <= whole_reg[2];
            wq_reg[1] <= recip_quot(whole_reg[2], RECIP_10, SHIFT_10);
            wq_reg[2] <= recip_quot(whole_reg[2], RECIP_100, SHIFT_100);
            wq_reg[3] <= recip_quot(whole_reg[2], RECIP_1000, SHIFT_1000);
            fq_reg[1] <= recip_quot(div2_q, RECIP_10, SHIFT_10);
            fq_reg[2] <= recip_quot(div2_q, RECIP_100, SHIFT_100);
            fq_reg[3] <= recip_quot(div2_q, RECIP_1000, SHIFT_1000);
        end
    end

    // stage 7: digits and whole digit count
    code_t              wdig_reg [4];
    code_t              fdig_reg [3];
    logic [POINT_W-1:0] nd_reg, nd_next;

    always_comb
    begin
        if (wq_reg[3] != '0)
            nd_next = POINT_W'(4);
        else if (wq_reg[2] != '0)
            nd_next = POINT_W'(3);
        else if (wq_reg[1] != '0)
            nd_next = POINT_W'(2);
        else
            nd_next = POINT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            wdig_reg[0] <= CODE_W'(wq_reg[0] - wq_reg[1] * TEN);
            wdig_reg[1] <= CODE_W'(wq_reg[1] - wq_reg[2] * TEN);
            wdig_reg[2] <= CODE_W'(wq_reg[2] - wq_reg[3] * TEN);
            wdig_reg[3] <= CODE_W'(wq_reg[3]);
            fdig_reg[0] <= CODE_W'(fq_reg[3]);
            fdig_reg[1] <= CODE_W'(fq_reg[2] - fq_reg[3] * TEN);
            fdig_reg[2] <= CODE_W'(fq_reg[1] - fq_reg[2] * TEN);
            nd_reg      <= nd_next;
        end
    end

    // stage 8: position layout into the output register
    code_t              pos_reg [NUM_POS];
    code_t              pos_next [NUM_POS];
    logic [POINT_W-1:0] point_reg, point_next;
    tag_t               t7;

    always_comb
    begin
        logic [POINT_W-1:0] k;
        logic [POINT_W-1:0] j;
        logic [POINT_W-1:0] m;
        t7 = tag_reg[NSTAGE-2];
        for (int i = 0; i < NUM_POS; i++)
        begin
            k = POINT_W'(i) - POINT_W'(t7.neg);
            j = POINT_W'(NUM_POS - 1 - i);
            m = k - nd_reg;
            if (t7.oor)
                pos_next[i] = CODE_OOR;
            else if (t7.fixed)
            begin
                if (t7.neg && i == 0)
                    pos_next[i] = CODE_MINUS;
                else if (k < nd_reg)
                    pos_next[i] = wdig_reg[2'(nd_reg - POINT_W'(1) - k)];
                else
                begin
                    case (m)
                        POINT_W'(0): pos_next[i] = fdig_reg[0];
                        POINT_W'(1): pos_next[i] = fdig_reg[1];
                        default:     pos_next[i] = fdig_reg[2];
                    endcase
                end
            end
            else
            begin
                if (j < nd_reg)
                    pos_next[i] = wdig_reg[2'(j)];
                else if (j == nd_reg && t7.neg)
                    pos_next[i] = CODE_MINUS;
                else
                    pos_next[i] = CODE_BLANK;
            end
        end
        if (!t7.fixed)
            point_next = POINT_NONE;
        else if (t7.oor)
            point_next = POINT_LAST;
        else
            point_next = POINT_W'(t7.neg) + nd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTAGE-1])
        begin
            pos_reg   <= pos_next;
            point_reg <= point_next;
        end
    end

    assign display.position_one   = pos_reg[0];
    assign display.position_two   = pos_reg[1];
    assign display.position_three = pos_reg[2];
    assign display.position_four  = pos_reg[3];
    assign display.point_position = point_reg;

    `ASSERT_ON(a_oor_whole_word, display.valid && pos_reg[0] == CODE_OOR, pos_reg[1] == CODE_OOR && pos_reg[2] == CODE_OOR && pos_reg[3] == CODE_OOR, "out-of-range word mixed with digits")
    `ASSERT_ON(a_point_bound, display.valid, point_reg <= POINT_LAST, "decimal point beyond last position")
    `ASSERT_ON(a_minus_not_last, display.valid, pos_reg[3] != CODE_MINUS, "minus sign in rightmost position")
    `ASSERT_NEXT(a_stall_holds_stage, valid_reg[NSTAGE-2] && !en[NSTAGE-1], valid_reg[NSTAGE-2], "word dropped behind stalled output")

endmodule

// ----- bench/signed_decimal_digit_formatter_checker.sv -----
// ----------------------------------------------------------------------------
// signed decimal digit formatter checker
// watches the sample, display and limit ports, works out the display word for
// every accepted sample and compares each delivered word with the oldest one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_decimal_digit_formatter_checker import sdf_pkg::*; #(
    parameter int FRACTION_SCALE = DEFAULT_FRACTION_SCALE
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sdf_sample_if                 sample,
    sdf_display_if                display,
    output int                    words_in_flight,
    output int                    failures
);

    typedef struct packed {
        code_t              position_one;
        code_t              position_two;
        code_t              position_three;
        code_t              position_four;
        logic [POINT_W-1:0] point_position;
    } display_word_t;

    logic signed [LOWER_W-1:0] lower_limit;
    logic [UPPER_W-1:0]        upper_limit;
    display_word_t             pending_words [$];
    int                        mismatch_count = 0;

    function automatic display_word_t format_display_word(
        input logic [KIND_W-1:0]         kind,
        input logic signed [VALUE_W-1:0] value,
        input logic signed [LOWER_W-1:0] lower,
        input logic [UPPER_W-1:0]        upper
    );
        longint        lo;
        longint        hi;
        longint        v;
        longint        mag;
        longint        whole;
        longint        frac;
        longint        fdiv;
        int            pos;
        int            n;
        int            nd;
        int            k;
        code_t         codes [NUM_POS];
        code_t         whole_digits [NUM_POS];
        display_word_t word;

        lo = lower;
        hi = upper;
        v  = value;
        // limits are clamped so every shown value fits four positions
        if (lo < NEG_CAP)
            lo = NEG_CAP;
        if (hi > POS_CAP)
            hi = POS_CAP;
        word.point_position = POINT_NONE;

        if (kind != KIND_FIXED)
        begin
            if (v < lo || v > hi)
            begin
                for (k = 0; k < NUM_POS; k++)
                    codes[k] = CODE_OOR;
            end
            else
            begin
                mag = (v < 0) ? -v : v;
                for (k = 0; k < NUM_POS; k++)
                    codes[k] = CODE_BLANK;
                pos = NUM_POS - 1;
                do
                begin
                    codes[pos] = code_t'(mag % 10);
                    mag        = mag / 10;
                    pos--;
                end
                while (mag != 0 && pos >= 0);
                if (v < 0 && pos >= 0)
                    codes[pos] = CODE_MINUS;
            end
        end
        else
        begin
            if (v < lo * FRACTION_SCALE || v > hi * FRACTION_SCALE)
            begin
                for (k = 0; k < NUM_POS; k++)
                    codes[k] = CODE_OOR;
                word.point_position = POINT_LAST;
            end
            else
            begin
                mag   = (v < 0) ? -v : v;
                whole = mag / FRACTION_SCALE;
                frac  = (mag % FRACTION_SCALE) * FRAC_DIGITS / FRACTION_SCALE;
                nd    = 0;
                do
                begin
                    whole_digits[nd] = code_t'(whole % 10);
                    whole            = whole / 10;
                    nd++;
                end
                while (whole != 0 && nd < NUM_POS);
                // sign first, even when the whole part is zero
                n = 0;
                if (v < 0)
                begin
                    codes[n] = CODE_MINUS;
                    n++;
                end
                for (k = nd; k > 0 && n < NUM_POS; k--)
                begin
                    codes[n] = whole_digits[k-1];
                    n++;
                end
                word.point_position = POINT_W'(n);
                fdiv = FRAC_DIGITS / 10;
                while (n < NUM_POS)
                begin
                    codes[n] = code_t'((frac / fdiv) % 10);
                    n++;
                    fdiv = fdiv / 10;
                    if (fdiv == 0)
                        fdiv = 1;
                end
            end
        end

        word.position_one   = codes[0];
        word.position_two   = codes[1];
        word.position_three = codes[2];
        word.position_four  = codes[3];
        return word;
    endfunction

    task automatic check_field(input string field, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want)
        begin
            $display("%0t checker: %s expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_limit <= LOWER_W'(NEG_CAP);
            upper_limit <= UPPER_W'(POS_CAP);
        end
        else if (cfg_we)
        begin
            if (cfg_reg_t'(cfg_index) == REG_LOWER_LIMIT)
                lower_limit <= cfg_data[LOWER_W-1:0];
            else
                upper_limit <= cfg_data[UPPER_W-1:0];
        end
    end

    always @(posedge clk)
    begin
        display_word_t want;
        if (rst_n)
        begin
            if (display.valid && display.ready)
            begin
                if (pending_words.size() == 0)
                begin
                    $display("%0t checker: unexpected word %0d %0d %0d %0d point %0d", $time,
                             display.position_one, display.position_two,
                             display.position_three, display.position_four,
                             display.point_position);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    check_field("position_one", want.position_one, display.position_one);
                    check_field("position_two", want.position_two, display.position_two);
                    check_field("position_three", want.position_three,
                                display.position_three);
                    check_field("position_four", want.position_four, display.position_four);
                    check_field("point_position", 4'(want.point_position),
                                4'(display.point_position));
                end
            end
            if (sample.valid && sample.ready)
                pending_words.push_back(format_display_word(sample.kind, sample.value,
                                                            lower_limit, upper_limit));
        end
        words_in_flight <= pending_words.size();
        failures        <= mismatch_count;
    end

endmodule

// ----- bench/signed_decimal_digit_formatter_tb.sv -----
// ----------------------------------------------------------------------------
// signed decimal digit formatter testbench
// directed edge values, then bursts of random samples under a series of limit
// settings, with random sender gaps and receiver stalls; checking is done by
// the checker module beside the block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_decimal_digit_formatter_tb import sdf_pkg::*; ();

    localparam logic [KIND_W-1:0] KIND_INTEGER = 1'b0;
    localparam int PHASE_WORDS      = 152;
    localparam int SETTLE_CYCLES    = 12;
    localparam int FIXED_SETTINGS   = 8;
    localparam int RANDOM_SETTINGS  = 4;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    words_in_flight;
    int                    failures;
    int                    aim_lower;
    int                    aim_upper;

    int setting_lower [FIXED_SETTINGS] = '{-999, 0, -1024, 1023, -1, -50, 10, -999};
    int setting_upper [FIXED_SETTINGS] = '{9999, 0, 16383, 0, 1, 125, 9998, 10000};

    sdf_sample_if  sample ();
    sdf_display_if display ();

    signed_decimal_digit_formatter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .display   (display)
    );

    signed_decimal_digit_formatter_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample          (sample),
        .display         (display),
        .words_in_flight (words_in_flight),
        .failures        (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver: switches between stall patterns every so often
    initial
    begin
        int mode;
        int mode_left;
        int cycle_count;
        mode            = 0;
        mode_left       = 0;
        cycle_count     = 0;
        display.ready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            cycle_count++;
            case (mode)
                0:       display.ready <= 1'b1;
                1:       display.ready <= 1'($urandom_range(0, 1));
                2:       display.ready <= ($urandom_range(0, 3) == 0);
                default: display.ready <= (cycle_count % 5) != 0;
            endcase
        end
    end

    task automatic push_sample(input logic [KIND_W-1:0] k, input logic signed [VALUE_W-1:0] v);
        sample.valid <= 1'b1;
        sample.kind  <= k;
        sample.value <= v;
        do
            @(posedge clk);
        while (!sample.ready);
    endtask

    task automatic drain();
        sample.valid <= 1'b0;
        @(posedge clk);
        while (words_in_flight != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limits(input int lower, input int upper);
        logic signed [LOWER_W-1:0] raw_lower;
        logic [UPPER_W-1:0]        raw_upper;
        raw_lower = LOWER_W'(lower);
        raw_upper = UPPER_W'(upper);
        aim_lower = (raw_lower < NEG_CAP) ? NEG_CAP : int'(raw_lower);
        aim_upper = (raw_upper > POS_CAP) ? POS_CAP : int'(raw_upper);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOWER_LIMIT;
        cfg_data  <= CFG_DATA_W'(lower);
        @(posedge clk);
        cfg_index <= REG_UPPER_LIMIT;
        cfg_data  <= CFG_DATA_W'(upper);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // values aimed around the current limits, with some wide noise
    function automatic logic signed [VALUE_W-1:0] pick_value(input logic [KIND_W-1:0] k);
        longint scale;
        longint a;
        longint b;
        longint r;
        int     digits;
        int     span;
        scale = (k == KIND_FIXED) ? DEFAULT_FRACTION_SCALE : 1;
        a     = aim_lower * scale;
        b     = aim_upper * scale;
        case ($urandom_range(0, 9))
            0: r = longint'($signed(VALUE_W'($urandom)));
            1:
            begin
                case ($urandom_range(0, 8))
                    0:       r = a - 1;
                    1:       r = a;
                    2:       r = a + 1;
                    3:       r = b - 1;
                    4:       r = b;
                    5:       r = b + 1;
                    6:       r = 0;
                    7:       r = -1;
                    default: r = 1;
                endcase
            end
            2: r = -longint'($urandom_range(1, (scale == 1) ? 9 : 9999));
            3:
            begin
                if ($urandom_range(0, 1))
                    r = a - longint'($urandom_range(0, 20 * 32'(scale)));
                else
                    r = b + longint'($urandom_range(0, 20 * 32'(scale)));
            end
            4, 5:
            begin
                digits = $urandom_range(1, 4);
                span   = 1;
                repeat (digits) span = span * 10;
                r = longint'($urandom_range(0, span - 1)) * scale;
                if (scale > 1)
                    r = r + longint'($urandom_range(0, 32'(scale) - 1));
                if ($urandom_range(0, 1))
                    r = -r;
            end
            default:
            begin
                if (a <= b)
                    r = a + longint'($urandom_range(0, 32'(b - a)));
                else
                    r = b + longint'($urandom_range(0, 32'(a - b)));
            end
        endcase
        return VALUE_W'(r);
    endfunction

    task automatic send_phase(input int count);
        int sent;
        int burst;
        int gap;
        int i;
        logic [KIND_W-1:0] k;
        sent = 0;
        while (sent < count)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            for (i = 0; i < burst && sent < count; i++)
            begin
                k = KIND_W'($urandom_range(0, 1));
                push_sample(k, pick_value(k));
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                // junk on the payload while the channel is idle
                sample.valid <= 1'b0;
                sample.kind  <= KIND_W'($urandom_range(0, 1));
                sample.value <= VALUE_W'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        int p;
        int lower;
        int upper;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_LOWER_LIMIT;
        cfg_data     = '0;
        sample.valid = 1'b0;
        sample.kind  = KIND_INTEGER;
        sample.value = '0;
        aim_lower    = NEG_CAP;
        aim_upper    = POS_CAP;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: edges of both modes
        push_sample(KIND_INTEGER, VALUE_W'(0));
        push_sample(KIND_INTEGER, VALUE_W'(9999));
        push_sample(KIND_INTEGER, VALUE_W'(10000));
        push_sample(KIND_INTEGER, VALUE_W'(-999));
        push_sample(KIND_INTEGER, VALUE_W'(-1000));
        push_sample(KIND_INTEGER, VALUE_W'(-5));
        push_sample(KIND_INTEGER, VALUE_W'(42));
        push_sample(KIND_INTEGER, VALUE_W'(134217727));
        push_sample(KIND_INTEGER, VALUE_W'(-134217728));
        push_sample(KIND_FIXED, VALUE_W'(0));
        push_sample(KIND_FIXED, VALUE_W'(99990000));
        push_sample(KIND_FIXED, VALUE_W'(99990001));
        push_sample(KIND_FIXED, VALUE_W'(-9990000));
        push_sample(KIND_FIXED, VALUE_W'(-9990001));
        push_sample(KIND_FIXED, VALUE_W'(-1));
        push_sample(KIND_FIXED, VALUE_W'(-12345));
        push_sample(KIND_FIXED, VALUE_W'(12345678));
        push_sample(KIND_FIXED, VALUE_W'(56789));
        push_sample(KIND_FIXED, VALUE_W'(134217727));
        push_sample(KIND_FIXED, VALUE_W'(-134217728));
        drain();

        for (p = 0; p < FIXED_SETTINGS + RANDOM_SETTINGS; p++)
        begin
            if (p < FIXED_SETTINGS)
            begin
                lower = setting_lower[p];
                upper = setting_upper[p];
            end
            else
            begin
                lower = $urandom_range(0, 1) ? -int'($urandom_range(0, 999))
                                             : int'($urandom_range(0, 2047)) - 1024;
                upper = $urandom_range(0, 1) ? int'($urandom_range(0, 9999))
                                             : int'($urandom_range(0, 16383));
            end
            write_limits(lower, upper);
            send_phase(PHASE_WORDS);
            drain();
        end

        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
